// ----- hdl/sec2date_pkg.sv -----
// Shared constants and month table for the seconds-to-calendar-date converter.
package sec2date_pkg;

   localparam int NUM_STAGES = 7;

   localparam logic [31:0] EPOCH_SHIFT  = 32'd432000;
   localparam logic [16:0] OFFSET_RESET = 17'd32400;
   localparam logic [11:0] BASE_YEAR    = 12'd1980;

   localparam logic [11:0] ZERO_YEAR  = 12'd1980;
   localparam logic [3:0]  ZERO_MONTH = 4'd1;
   localparam logic [4:0]  ZERO_DAY   = 5'd6;

   // days = (sum >> 7) / 675, estimate from reciprocal with k = 35
   localparam logic [9:0]  DAY_DIV   = 10'd675;
   localparam logic [25:0] DAY_RECIP = 26'((64'd1 << 35) / 64'd675);

   // four-year cycle: days / 1461, k = 27
   localparam logic [10:0] QUAD_DIV   = 11'd1461;
   localparam logic [16:0] QUAD_RECIP = 17'((64'd1 << 27) / 64'd1461);

   // hour = (sod >> 4) / 225, k = 21
   localparam logic [7:0]  HOUR_DIV   = 8'd225;
   localparam logic [13:0] HOUR_RECIP = 14'((64'd1 << 21) / 64'd225);

   // minute = (mss >> 2) / 15, k = 14
   localparam logic [3:0]  MIN_DIV   = 4'd15;
   localparam logic [10:0] MIN_RECIP = 11'((64'd1 << 14) / 64'd15);

   localparam logic [10:0] YEAR1_START = 11'd366;
   localparam logic [10:0] YEAR2_START = 11'd731;
   localparam logic [10:0] YEAR3_START = 11'd1096;

   // cumulative days before month idx (0-based); leap adds a day from March on
   function automatic logic [8:0] month_start(input logic leap, input logic [3:0] idx);
      logic [8:0] base;
      begin
         case (idx)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd31;
            4'd2:    base = 9'd59;
            4'd3:    base = 9'd90;
            4'd4:    base = 9'd120;
            4'd5:    base = 9'd151;
            4'd6:    base = 9'd181;
            4'd7:    base = 9'd212;
            4'd8:    base = 9'd243;
            4'd9:    base = 9'd273;
            4'd10:   base = 9'd304;
            4'd11:   base = 9'd334;
            default: base = 9'd365;
         endcase
         if (leap && (idx >= 4'd2)) begin
            base = base + 9'd1;
         end
         return base;
      end
   endfunction

endpackage

// ----- hdl/seconds_to_calendar_date.sv -----
// Seconds-since-1980 to local calendar date and time converter, pipelined.
//
// Input channel req_*: one beat carries a 32-bit count of seconds since
// 1980-01-06 00:00:00. Output channel rsp_*: one beat per input beat with
// year, month, day of month, hour, minute and second, in input order.
// csr_wr_en/csr_wr_data write the 17-bit local time offset (reset 32400 s);
// write it only while no beat is in flight.
// Seven register stages: a beat accepted into stage 1 moves through stages
// 2 to 7 in order to rsp_*. One beat per cycle is sustained unless stalled;
// the reciprocal multiply and correct pairs for the day, four-year cycle,
// hour and minute splits set the stage count. Each stage holds its beat
// while the next one is full and stalled, so a stall on rsp_stall fills
// empty stages first and then raises req_stall. Reset (synchronous, active
// high) empties the pipeline and reloads the offset register. An input of
// zero yields 1980-01-06 00:00:00.
module seconds_to_calendar_date (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [16:0] csr_wr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_elapsed_seconds,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [11:0] rsp_year,
   output logic [3:0]  rsp_month,
   output logic [4:0]  rsp_day_of_month,
   output logic [4:0]  rsp_hour,
   output logic [5:0]  rsp_minute,
   output logic [5:0]  rsp_second
);

   localparam int NS = sec2date_pkg::NUM_STAGES;

   logic [16:0]   offset_ff;
   logic [NS-1:0] valid_ff;
   logic [NS-1:0] valid_in;
   logic [NS-1:0] ready;

   // stage 1: shifted sum
   logic [31:0] s1_sum_ff, s1_sum_in;
   logic        s1_zero_ff;
   // stage 2: day estimate
   logic [50:0] day_prod;
   logic [15:0] s2_qday_ff;
   logic [24:0] s2_x_ff;
   logic [6:0]  s2_low_ff;
   logic        s2_zero_ff;
   // stage 3: day correction
   logic [24:0] day_back, day_rem;
   logic [15:0] s3_days_ff, s3_days_in;
   logic [16:0] s3_sod_ff, s3_sod_in;
   logic        s3_zero_ff;
   // stage 4: hour and cycle estimates
   logic [26:0] hour_prod;
   logic [32:0] quad_prod;
   logic [4:0]  s4_qhour_ff;
   logic [5:0]  s4_qquad_ff;
   logic [15:0] s4_days_ff;
   logic [16:0] s4_sod_ff;
   logic        s4_zero_ff;
   // stage 5: hour and cycle corrections
   logic [12:0] hour_back, hour_rem;
   logic [15:0] quad_back, quad_rem;
   logic [4:0]  s5_hour_ff, s5_hour_in;
   logic [11:0] s5_mss_ff, s5_mss_in;
   logic [5:0]  s5_quad_ff, s5_quad_in;
   logic [10:0] s5_rquad_ff, s5_rquad_in;
   logic        s5_zero_ff;
   // stage 6: minute estimate, year within cycle
   logic [20:0] min_prod;
   logic [1:0]  yi;
   logic [10:0] yr_start;
   logic [5:0]  s6_qmin_ff;
   logic [11:0] s6_mss_ff;
   logic [4:0]  s6_hour_ff;
   logic [11:0] s6_year_ff, s6_year_in;
   logic [8:0]  s6_ryear_ff, s6_ryear_in;
   logic        s6_leap_ff;
   logic        s6_zero_ff;
   // stage 7: output
   logic [9:0]  min_back, min_rem;
   logic [3:0]  mi;
   logic [8:0]  mstart;
   logic [11:0] s7_year_in;
   logic [3:0]  s7_month_in;
   logic [4:0]  s7_day_in;
   logic [4:0]  s7_hour_in;
   logic [5:0]  s7_min_in, s7_min_calc;
   logic [5:0]  s7_sec_in, s7_sec_calc;
   logic [11:0] s7_year_ff;
   logic [3:0]  s7_month_ff;
   logic [4:0]  s7_day_ff;
   logic [4:0]  s7_hour_ff;
   logic [5:0]  s7_min_ff;
   logic [5:0]  s7_sec_ff;

   // handshake
   always_comb begin
      ready[NS-1] = !valid_ff[NS-1] || !rsp_stall;
      for (int i = NS - 2; i >= 0; i--) begin
         ready[i] = !valid_ff[i] || ready[i+1];
      end
      valid_in[0] = req_valid;
      for (int i = 1; i < NS; i++) begin
         valid_in[i] = valid_ff[i-1];
      end
   end

   assign req_stall = !ready[0];
   assign rsp_valid = valid_ff[NS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         offset_ff <= sec2date_pkg::OFFSET_RESET;
      end else begin
         for (int i = 0; i < NS; i++) begin
            if (ready[i]) begin
               valid_ff[i] <= valid_in[i];
            end
         end
         if (csr_wr_en) begin
            offset_ff <= csr_wr_data;
         end
      end
   end

   // stage 1
   assign s1_sum_in = req_elapsed_seconds + sec2date_pkg::EPOCH_SHIFT + {15'd0, offset_ff};

   always_ff @(posedge clock) begin
      if (ready[0]) begin
         s1_sum_ff  <= s1_sum_in;
         s1_zero_ff <= (req_elapsed_seconds == 32'd0);
      end
   end

   // stage 2
   assign day_prod = {26'd0, s1_sum_ff[31:7]} * {25'd0, sec2date_pkg::DAY_RECIP};

   always_ff @(posedge clock) begin
      if (ready[1]) begin
         s2_qday_ff <= day_prod[50:35];
         s2_x_ff    <= s1_sum_ff[31:7];
         s2_low_ff  <= s1_sum_ff[6:0];
         s2_zero_ff <= s1_zero_ff;
      end
   end

   // stage 3
   always_comb begin
      day_back = {9'd0, s2_qday_ff} * {15'd0, sec2date_pkg::DAY_DIV};
      day_rem  = s2_x_ff - day_back;
      if (day_rem >= {15'd0, sec2date_pkg::DAY_DIV}) begin
         s3_days_in = s2_qday_ff + 16'd1;
         day_rem    = day_rem - {15'd0, sec2date_pkg::DAY_DIV};
      end else begin
         s3_days_in = s2_qday_ff;
      end
      s3_sod_in = {day_rem[9:0], s2_low_ff};
   end

   always_ff @(posedge clock) begin
      if (ready[2]) begin
         s3_days_ff <= s3_days_in;
         s3_sod_ff  <= s3_sod_in;
         s3_zero_ff <= s2_zero_ff;
      end
   end

   // stage 4
   assign hour_prod = {14'd0, s3_sod_ff[16:4]} * {13'd0, sec2date_pkg::HOUR_RECIP};
   assign quad_prod = {17'd0, s3_days_ff} * {16'd0, sec2date_pkg::QUAD_RECIP};

   always_ff @(posedge clock) begin
      if (ready[3]) begin
         s4_qhour_ff <= hour_prod[25:21];
         s4_qquad_ff <= quad_prod[32:27];
         s4_days_ff  <= s3_days_ff;
         s4_sod_ff   <= s3_sod_ff;
         s4_zero_ff  <= s3_zero_ff;
      end
   end

   // stage 5
   always_comb begin
      hour_back = {8'd0, s4_qhour_ff} * {5'd0, sec2date_pkg::HOUR_DIV};
      hour_rem  = s4_sod_ff[16:4] - hour_back;
      if (hour_rem >= {5'd0, sec2date_pkg::HOUR_DIV}) begin
         s5_hour_in = s4_qhour_ff + 5'd1;
         hour_rem   = hour_rem - {5'd0, sec2date_pkg::HOUR_DIV};
      end else begin
         s5_hour_in = s4_qhour_ff;
      end
      s5_mss_in = {hour_rem[7:0], s4_sod_ff[3:0]};

      quad_back = {10'd0, s4_qquad_ff} * {5'd0, sec2date_pkg::QUAD_DIV};
      quad_rem  = s4_days_ff - quad_back;
      if (quad_rem >= {5'd0, sec2date_pkg::QUAD_DIV}) begin
         s5_quad_in = s4_qquad_ff + 6'd1;
         quad_rem   = quad_rem - {5'd0, sec2date_pkg::QUAD_DIV};
      end else begin
         s5_quad_in = s4_qquad_ff;
      end
      s5_rquad_in = quad_rem[10:0];
   end

   always_ff @(posedge clock) begin
      if (ready[4]) begin
         s5_hour_ff  <= s5_hour_in;
         s5_mss_ff   <= s5_mss_in;
         s5_quad_ff  <= s5_quad_in;
         s5_rquad_ff <= s5_rquad_in;
         s5_zero_ff  <= s4_zero_ff;
      end
   end

   // stage 6
   assign min_prod = {11'd0, s5_mss_ff[11:2]} * {10'd0, sec2date_pkg::MIN_RECIP};

   always_comb begin
      if (s5_rquad_ff >= sec2date_pkg::YEAR3_START) begin
         yi       = 2'd3;
         yr_start = sec2date_pkg::YEAR3_START;
      end else if (s5_rquad_ff >= sec2date_pkg::YEAR2_START) begin
         yi       = 2'd2;
         yr_start = sec2date_pkg::YEAR2_START;
      end else if (s5_rquad_ff >= sec2date_pkg::YEAR1_START) begin
         yi       = 2'd1;
         yr_start = sec2date_pkg::YEAR1_START;
      end else begin
         yi       = 2'd0;
         yr_start = 11'd0;
      end
      s6_ryear_in = 9'(s5_rquad_ff - yr_start);
      s6_year_in  = sec2date_pkg::BASE_YEAR + {4'd0, s5_quad_ff, 2'b00} + {10'd0, yi};
   end

   always_ff @(posedge clock) begin
      if (ready[5]) begin
         s6_qmin_ff  <= min_prod[19:14];
         s6_mss_ff   <= s5_mss_ff;
         s6_hour_ff  <= s5_hour_ff;
         s6_year_ff  <= s6_year_in;
         s6_ryear_ff <= s6_ryear_in;
         s6_leap_ff  <= (yi == 2'd0);
         s6_zero_ff  <= s5_zero_ff;
      end
   end

   // stage 7
   always_comb begin
      min_back = {4'd0, s6_qmin_ff} * {6'd0, sec2date_pkg::MIN_DIV};
      min_rem  = s6_mss_ff[11:2] - min_back;
      if (min_rem >= {6'd0, sec2date_pkg::MIN_DIV}) begin
         s7_min_calc = s6_qmin_ff + 6'd1;
         min_rem     = min_rem - {6'd0, sec2date_pkg::MIN_DIV};
      end else begin
         s7_min_calc = s6_qmin_ff;
      end
      s7_sec_calc = {min_rem[3:0], s6_mss_ff[1:0]};

      mi = 4'd0;
      for (int m = 1; m < 12; m++) begin
         if (s6_ryear_ff >= sec2date_pkg::month_start(s6_leap_ff, 4'(m))) begin
            mi = 4'(m);
         end
      end
      mstart = sec2date_pkg::month_start(s6_leap_ff, mi);

      if (s6_zero_ff) begin
         s7_year_in  = sec2date_pkg::ZERO_YEAR;
         s7_month_in = sec2date_pkg::ZERO_MONTH;
         s7_day_in   = sec2date_pkg::ZERO_DAY;
         s7_hour_in  = 5'd0;
         s7_min_in   = 6'd0;
         s7_sec_in   = 6'd0;
      end else begin
         s7_year_in  = s6_year_ff;
         s7_month_in = mi + 4'd1;
         s7_day_in   = 5'(s6_ryear_ff - mstart + 9'd1);
         s7_hour_in  = s6_hour_ff;
         s7_min_in   = s7_min_calc;
         s7_sec_in   = s7_sec_calc;
      end
   end

   always_ff @(posedge clock) begin
      if (ready[6]) begin
         s7_year_ff  <= s7_year_in;
         s7_month_ff <= s7_month_in;
         s7_day_ff   <= s7_day_in;
         s7_hour_ff  <= s7_hour_in;
         s7_min_ff   <= s7_min_in;
         s7_sec_ff   <= s7_sec_in;
      end
   end

   assign rsp_year         = s7_year_ff;
   assign rsp_month        = s7_month_ff;
   assign rsp_day_of_month = s7_day_ff;
   assign rsp_hour         = s7_hour_ff;
   assign rsp_minute       = s7_min_ff;
   assign rsp_second       = s7_sec_ff;

endmodule

// ----- test/date_checker.sv -----
// Checker for seconds_to_calendar_date: predicts each date from the request beats and compares.
module date_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [16:0] csr_wr_data,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [31:0] req_elapsed_seconds,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [11:0] rsp_year,
   input  logic [3:0]  rsp_month,
   input  logic [4:0]  rsp_day_of_month,
   input  logic [4:0]  rsp_hour,
   input  logic [5:0]  rsp_minute,
   input  logic [5:0]  rsp_second,
   output int          fail_count,
   output int          pending
);

   localparam logic [16:0] DEFAULT_OFFSET = 17'd32400;
   localparam logic [31:0] EPOCH_SHIFT_S  = 32'd432000;
   localparam int unsigned DAYS_PER_QUAD  = 1461;

   typedef struct packed {
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
   } cal_date_type;

   cal_date_type expected_dates[$];
   logic [16:0]  local_offset;

   // days elapsed in the year before month idx (0-based)
   function automatic int unsigned days_before_month(input bit leap, input int unsigned idx);
      int unsigned n;
      case (idx)
         0:       n = 0;
         1:       n = 31;
         2:       n = 59;
         3:       n = 90;
         4:       n = 120;
         5:       n = 151;
         6:       n = 181;
         7:       n = 212;
         8:       n = 243;
         9:       n = 273;
         10:      n = 304;
         11:      n = 334;
         default: n = 365;
      endcase
      if (leap && idx >= 2) begin
         n = n + 1;
      end
      return n;
   endfunction

   function automatic cal_date_type seconds_to_date(input logic [31:0] elapsed,
                                                    input logic [16:0] offset);
      cal_date_type d;
      logic [31:0]  total;
      int unsigned  days, rem, yi, mi;
      if (elapsed == 32'd0) begin
         d.year   = 12'd1980;
         d.month  = 4'd1;
         d.day    = 5'd6;
         d.hour   = 5'd0;
         d.minute = 6'd0;
         d.second = 6'd0;
         return d;
      end
      total    = elapsed + EPOCH_SHIFT_S + {15'd0, offset};
      d.second = 6'(total % 60);
      total    = total / 60;
      d.minute = 6'(total % 60);
      total    = total / 60;
      d.hour   = 5'(total % 24);
      days     = total / 24;
      rem      = days % DAYS_PER_QUAD;
      yi = 0;
      while (yi < 3 && rem >= 365 * (yi + 1) + 1) begin
         yi++;
      end
      if (yi != 0) begin
         rem = rem - (365 * yi + 1);
      end
      mi = 0;
      while (mi < 11 && rem >= days_before_month(yi == 0, mi + 1)) begin
         mi++;
      end
      d.day   = 5'(rem - days_before_month(yi == 0, mi) + 1);
      d.month = 4'(mi + 1);
      d.year  = 12'(1980 + 4 * (days / DAYS_PER_QUAD) + yi);
      return d;
   endfunction

   always @(posedge clock) begin : check_beats
      cal_date_type want;
      cal_date_type got;
      int           bad;
      if (reset) begin
         expected_dates.delete();
         local_offset = DEFAULT_OFFSET;
         pending    <= 0;
         fail_count <= 0;
      end else begin
         bad = 0;
         if (csr_wr_en) begin
            local_offset = csr_wr_data;
         end
         // older beats leave before the new one is queued
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_year, rsp_month, rsp_day_of_month, rsp_hour, rsp_minute, rsp_second};
            if (expected_dates.size() == 0) begin
               $error("result beat with no date expected: %0d-%0d-%0d %0d:%0d:%0d",
                      got.year, got.month, got.day, got.hour, got.minute, got.second);
               bad++;
            end else begin
               want = expected_dates.pop_front();
               if (got.year !== want.year) begin
                  $error("year: expected %0d, got %0d", want.year, got.year);
                  bad++;
               end
               if (got.month !== want.month) begin
                  $error("month: expected %0d, got %0d", want.month, got.month);
                  bad++;
               end
               if (got.day !== want.day) begin
                  $error("day_of_month: expected %0d, got %0d", want.day, got.day);
                  bad++;
               end
               if (got.hour !== want.hour) begin
                  $error("hour: expected %0d, got %0d", want.hour, got.hour);
                  bad++;
               end
               if (got.minute !== want.minute) begin
                  $error("minute: expected %0d, got %0d", want.minute, got.minute);
                  bad++;
               end
               if (got.second !== want.second) begin
                  $error("second: expected %0d, got %0d", want.second, got.second);
                  bad++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            expected_dates.push_back(seconds_to_date(req_elapsed_seconds, local_offset));
         end
         pending    <= expected_dates.size();
         fail_count <= fail_count + bad;
      end
   end

endmodule

// ----- test/tb_seconds_to_calendar_date.sv -----
// Testbench top for seconds_to_calendar_date: drives timestamps and offsets, gives the verdict.
module tb_seconds_to_calendar_date;

   localparam int IDLE_LIMIT   = 2000;
   localparam int PHASES       = 6;
   localparam int PHASE_BEATS  = 225;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_wr_en;
   logic [16:0] csr_wr_data;
   logic        req_valid;
   logic        req_stall;
   logic [31:0] req_elapsed_seconds;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [11:0] rsp_year;
   logic [3:0]  rsp_month;
   logic [4:0]  rsp_day_of_month;
   logic [4:0]  rsp_hour;
   logic [5:0]  rsp_minute;
   logic [5:0]  rsp_second;

   int          fail_count;
   int          pending;
   int          idle_cycles;
   bit          quiet;
   logic [16:0] local_offset;

   seconds_to_calendar_date dut (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_elapsed_seconds(req_elapsed_seconds),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_year           (rsp_year),
      .rsp_month          (rsp_month),
      .rsp_day_of_month   (rsp_day_of_month),
      .rsp_hour           (rsp_hour),
      .rsp_minute         (rsp_minute),
      .rsp_second         (rsp_second)
   );

   date_checker date_chk (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_elapsed_seconds(req_elapsed_seconds),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_year           (rsp_year),
      .rsp_month          (rsp_month),
      .rsp_day_of_month   (rsp_day_of_month),
      .rsp_hour           (rsp_hour),
      .rsp_minute         (rsp_minute),
      .rsp_second         (rsp_second),
      .fail_count         (fail_count),
      .pending            (pending)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      wait (idle_cycles >= IDLE_LIMIT);
      $display("FAIL");
      $finish;
   end

   // result side: random stall before each beat, none while quiet
   initial begin
      int unsigned hold;
      rsp_stall = 1'b0;
      forever begin
         hold = quiet ? 0 : $urandom_range(0, 4);
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!rsp_valid);
      end
   end

   function automatic logic [31:0] pick_elapsed();
      int unsigned day_in_quad;
      logic [31:0] v;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: v = $urandom;
         4: v = $urandom_range(0, 200000);
         5: v = 32'hFFFF_FFFF - $urandom_range(0, 700000);
         6: v = 32'($urandom_range(0, 49709) * 86400 + $urandom_range(0, 4) - 2
                    - 432000 - local_offset);
         7: begin
            case ($urandom_range(0, 12))
               0:       day_in_quad = 0;
               1:       day_in_quad = 58;
               2:       day_in_quad = 59;
               3:       day_in_quad = 60;
               4:       day_in_quad = 365;
               5:       day_in_quad = 366;
               6:       day_in_quad = 424;
               7:       day_in_quad = 425;
               8:       day_in_quad = 730;
               9:       day_in_quad = 731;
               10:      day_in_quad = 1095;
               11:      day_in_quad = 1096;
               default: day_in_quad = 1460;
            endcase
            v = 32'(($urandom_range(0, 33) * 1461 + day_in_quad) * 86400
                    + $urandom_range(0, 86399) - 432000 - local_offset);
         end
         8: begin
            case ($urandom_range(0, 2))
               0:       v = 32'd0;
               1:       v = 32'd1;
               default: v = 32'hFFFF_FFFF;
            endcase
         end
         default: v = {2'b11, 30'($urandom)};
      endcase
      return v;
   endfunction

   task automatic send_beat(input logic [31:0] secs);
      int unsigned gap;
      gap = quiet ? 0 : $urandom_range(0, 4);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_elapsed_seconds <= secs;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic write_offset(input logic [16:0] value);
      drain_results();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en    <= 1'b0;
      local_offset = value;
   endtask

   initial begin
      logic [16:0] next_offset;
      reset               = 1'b1;
      csr_wr_en           = 1'b0;
      csr_wr_data         = '0;
      req_valid           = 1'b0;
      req_elapsed_seconds = '0;
      quiet               = 1'b0;
      local_offset        = sec2date_pkg::OFFSET_RESET;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset offset: epoch, wrap edges, leap day, year and quad boundaries
      send_beat(32'd0);
      send_beat(32'd1);
      send_beat(32'd59);
      send_beat(32'd3599);
      send_beat(32'd86399);
      send_beat(32'hFFFF_FFFF);
      send_beat(32'h8000_0000);
      send_beat(32'h7FFF_FFFF);
      send_beat(32'd4294502895);
      send_beat(32'd4294502896);
      send_beat(32'd4633200);
      send_beat(32'd31071600);
      send_beat(32'd31158000);
      send_beat(32'd36169200);
      send_beat(32'd36255600);
      send_beat(32'd125679600);
      send_beat(32'd125766000);

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0:       next_offset = 17'd0;
            1:       next_offset = 17'h1FFFF;
            2:       next_offset = 17'd86399;
            5:       next_offset = sec2date_pkg::OFFSET_RESET;
            default: next_offset = 17'($urandom_range(0, 131071));
         endcase
         write_offset(next_offset);
         if (p == 0) begin
            send_beat(32'd4294535295);
            send_beat(32'd4294535296);
         end else if (p == 1) begin
            // zero ignores the offset; max input wraps with the widest offset
            send_beat(32'd0);
            send_beat(32'hFFFF_FFFF);
         end
         for (int i = 0; i < PHASE_BEATS; i++) begin
            quiet = (p % 2 == 1) && (i < 80);
            if (p == 2 && i == PHASE_BEATS / 2) begin
               drain_results();
            end
            send_beat(pick_elapsed());
         end
         quiet = 1'b0;
      end

      drain_results();
      repeat (sec2date_pkg::NUM_STAGES + 4) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
